### src/mccs_pkg.sv
// Package for the mark-compact chunk store: cell encoding, commands, widths.
// No dependencies.
`default_nettype none
package mccs_pkg;
    localparam int unsigned AddrW = 16;
    localparam int unsigned LvlW = 17;
    localparam logic [LvlW-1:0] StoreCells = 17'd65536;

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_READ = 3'd1,
        CMD_ALLOC = 3'd2,
        CMD_RAW = 3'd3,
        CMD_RECLAIM = 3'd4
    } t_cmd;

    localparam logic [3:0] CellPtr = 4'h1;
    localparam logic [3:0] CellHdr = 4'h5;
    localparam logic [3:0] CellHdrRaw = 4'hD;
    localparam logic [3:0] CellLink = 4'h3;

    typedef struct packed {
        logic [2:0] command;
        logic [15:0] address;
        logic [31:0] cell_value;
        logic [15:0] size;
        logic [3:0] tag;
        logic [16:0] margin;
    } t_cmd_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] chunk_offset;
        logic [16:0] free_level;
        logic status;
    } t_result;

    // pointer cell: keep low 3 bits, offset in 31:3
    function automatic logic [31:0] put_offset(input logic [31:0] low, input logic [28:0] ofs);
        put_offset = {ofs, low[2:0]};
    endfunction
endpackage
`default_nettype wire

### src/mccs_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on mccs_pkg.
`default_nettype none
interface mccs_cmd_if;
    logic valid;
    logic ready;
    mccs_pkg::t_cmd_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mccs_res_if;
    logic valid;
    logic ready;
    mccs_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/mark_compact_chunk_store.sv
// Mark-compact chunk store top level: a sequencer around one 64K x 32 cell memory.
// A write stores the cell directly; a read passes S_RD and S_RDW. Allocation writes the
// header, then zeroes its size cells (one cell a cycle); a raw one writes the header only.
// Reclaim runs a marking walk, an update pass and a slide pass; a held result adds stalls.
// One command in flight at a time; the memory port sets the rate.
// Synchronous active-low reset clears control state; cell memory is undefined until written.
`default_nettype none
module mark_compact_chunk_store (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_cfg_we,
    input wire logic [16:0] i_cfg_wdata,
    mccs_cmd_if.sink i_cmd,
    mccs_res_if.source o_res
);
    import mccs_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE  = 18'd1,
        S_RD    = 18'd2,
        S_FILL  = 18'd4,
        S_MRD   = 18'd8,
        S_MEX   = 18'd16,
        S_MPRV  = 18'd32,
        S_MPRV2 = 18'd64,
        S_URD   = 18'd128,
        S_UEX   = 18'd256,
        S_ULRD  = 18'd512,
        S_ULEX  = 18'd1024,
        S_CRD   = 18'd2048,
        S_CEX   = 18'd4096,
        S_CMRD  = 18'd8192,
        S_CMWR  = 18'd16384,
        S_DONE  = 18'd32768,
        S_OUT   = 18'd65536,
        S_RDW   = 18'd131072
    } t_state;

    logic [31:0] r_mem [0:65535];
    logic [31:0] r_rdata;
    logic [15:0] n_raddr;
    logic n_we;
    logic [15:0] n_waddr;
    logic [31:0] n_wdata;

    t_state r_state, n_state;
    logic [16:0] r_top, r_free, n_free;
    logic [28:0] r_prv, n_prv;
    logic [16:0] r_cur, n_cur;
    logic [16:0] r_src, n_src, r_dst, n_dst;
    logic [16:0] r_cnt, n_cnt;
    logic [18:0] r_budget, n_budget;
    logic [31:0] r_cel, n_cel;
    logic [31:0] r_fresh, n_fresh;
    logic [1:0] r_pass, n_pass;
    t_cmd_item r_cmd, n_cmd;
    t_result r_res, n_res;
    logic r_ovalid, n_ovalid;

    logic [16:0] lim;
    logic [17:0] alloc_end;
    logic [31:0] size_cel;
    logic [24:0] cell_n;
    logic [24:0] src_end;

    assign lim = (r_top < StoreCells) ? r_top : StoreCells;
    assign alloc_end = {1'b0, r_free} + {2'd0, r_cmd.size} + 18'd1;
    assign size_cel = (r_state == S_CEX) ? r_rdata : r_cel;
    assign cell_n = {1'b0, size_cel[31:8]} + 25'd1;
    assign src_end = {8'd0, r_src} + cell_n;

    assign i_cmd.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_res.valid = r_ovalid;
    assign o_res.data = r_res;

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        r_rdata <= r_mem[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top <= 17'd65536;
            r_free <= '0;
            r_prv <= '0;
            r_cur <= '0;
            r_src <= '0;
            r_dst <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top <= i_cfg_we ? i_cfg_wdata : r_top;
            r_free <= n_free;
            r_prv <= n_prv;
            r_cur <= n_cur;
            r_src <= n_src;
            r_dst <= n_dst;
            r_ovalid <= n_ovalid;
        end
        r_cnt <= n_cnt;
        r_budget <= n_budget;
        r_cel <= n_cel;
        r_fresh <= n_fresh;
        r_pass <= n_pass;
        r_cmd <= n_cmd;
        r_res <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_free = r_free;
        n_prv = r_prv;
        n_cur = r_cur;
        n_src = r_src;
        n_dst = r_dst;
        n_cnt = r_cnt;
        n_budget = r_budget;
        n_cel = r_cel;
        n_fresh = r_fresh;
        n_pass = r_pass;
        n_cmd = r_cmd;
        n_res = r_res;
        n_ovalid = r_ovalid && !o_res.ready;
        n_raddr = '0;
        n_we = 1'b0;
        n_waddr = '0;
        n_wdata = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid && i_cmd.ready) begin
                    n_cmd = i_cmd.data;
                    n_res = '0;
                    n_raddr = i_cmd.data.address;
                    priority case (i_cmd.data.command)
                        CMD_WRITE: begin
                            n_we = 1'b1;
                            n_waddr = i_cmd.data.address;
                            n_wdata = i_cmd.data.cell_value;
                            n_state = S_DONE;
                        end
                        CMD_READ: n_state = S_RD;
                        CMD_ALLOC, CMD_RAW: n_state = S_FILL;
                        CMD_RECLAIM: begin
                            n_prv = {12'd0, r_free};
                            n_cur = '0;
                            n_src = '0;
                            n_dst = '0;
                            n_budget = {r_free, 2'b00} + 19'd4;
                            n_state = (r_free == '0) ? S_CRD : S_MRD;
                        end
                        default: n_state = S_DONE;
                    endcase
                    n_cnt = '0;
                end
            end
            S_RD: begin
                n_raddr = r_cmd.address;
                n_state = S_RDW;
            end
            S_RDW: begin
                n_res.read_data = r_rdata;
                n_state = S_DONE;
            end
            S_FILL: begin
                if (r_cnt == '0) begin
                    if (alloc_end > {1'b0, lim}) begin
                        n_res.status = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_we = 1'b1;
                        n_waddr = r_free[15:0];
                        n_wdata = {8'd0, r_cmd.size, r_cmd.tag,
                                   (r_cmd.command == CMD_ALLOC) ? CellHdr : CellHdrRaw};
                        n_res.chunk_offset = r_free[15:0];
                        n_cnt = 17'd1;
                        if (r_cmd.command != CMD_ALLOC || r_cmd.size == '0) begin
                            n_free = alloc_end[16:0];
                            n_state = S_DONE;
                        end
                    end
                end else begin
                    n_we = 1'b1;
                    n_waddr = r_free[15:0] + r_cnt[15:0];
                    n_wdata = '0;
                    n_cnt = r_cnt + 17'd1;
                    if (r_cnt == {1'b0, r_cmd.size}) begin
                        n_free = alloc_end[16:0];
                        n_state = S_DONE;
                    end
                end
            end
            // marking walk
            S_MRD: begin
                if (r_budget == '0 || r_cur >= r_free) begin
                    n_res.status = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_budget = r_budget - 19'd1;
                    n_raddr = r_cur[15:0];
                    n_state = S_MEX;
                end
            end
            S_MEX: begin
                n_cel = r_rdata;
                n_state = S_MRD;
                unique case (r_rdata[3:0])
                    4'd1, 4'd9: begin
                        n_we = 1'b1;
                        n_waddr = r_cur[15:0];
                        n_wdata = put_offset(r_rdata, r_prv);
                        n_prv = {12'd0, r_cur};
                        n_cur = r_rdata[19:3];
                        if (r_rdata[31:20] != '0) n_cur = 17'h1FFFF;
                    end
                    4'd5: begin
                        n_we = 1'b1;
                        n_waddr = r_cur[15:0];
                        n_wdata = r_rdata | 32'd2;
                        n_cur = ({1'b0, r_cur} + {1'b0, r_rdata[24:8]} > 18'h1FFFF ||
                                 r_rdata[31:25] != '0) ? 17'h1FFFF
                                : r_cur + r_rdata[24:8];
                    end
                    4'd13: begin
                        n_we = 1'b1;
                        n_waddr = r_cur[15:0];
                        n_wdata = r_rdata | 32'd2;
                    end
                    4'd3, 4'd7, 4'd11, 4'd15: begin
                        if (r_prv >= {12'd0, r_free}) begin
                            n_src = '0;
                            n_dst = '0;
                            n_cnt = r_free;
                            n_pass = 2'd1;
                            n_state = S_URD;
                        end else begin
                            n_raddr = r_prv[15:0];
                            n_state = S_MPRV;
                        end
                    end
                    default: begin
                        n_cur = r_cur - 17'd1;
                        if (r_cur == '0) n_cur = 17'h1FFFF;
                    end
                endcase
            end
            S_MPRV: begin
                n_raddr = r_prv[15:0];
                n_state = S_MPRV2;
            end
            S_MPRV2: begin
                n_we = 1'b1;
                n_waddr = r_prv[15:0];
                n_wdata = r_cel;
                n_fresh = r_rdata;
                n_state = S_CMWR;
                n_pass = 2'd0;
            end
            // update pass
            S_URD: begin
                if (r_src >= r_free) begin
                    n_src = '0;
                    n_dst = '0;
                    n_state = S_CRD;
                end else begin
                    n_raddr = r_src[15:0];
                    n_state = S_UEX;
                end
            end
            S_UEX: begin
                n_cel = r_rdata;
                if (!r_rdata[2]) begin
                    n_fresh = put_offset({28'd0, CellPtr}, {12'd0, r_dst});
                    n_state = S_ULRD;
                end else begin
                    n_state = S_ULEX;
                    n_pass = 2'd2;
                end
            end
            S_ULRD: begin
                if (r_cel[31:3] >= {12'd0, r_free} || r_cnt == '0) begin
                    n_res.status = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 17'd1;
                    n_raddr = r_cel[18:3];
                    n_pass = 2'd1;
                    n_state = S_ULEX;
                end
            end
            S_ULEX: begin
                if (r_pass == 2'd1) begin
                    n_we = 1'b1;
                    n_waddr = r_cel[18:3];
                    n_wdata = r_fresh;
                    n_cel = r_rdata;
                    if (!r_rdata[2]) begin
                        n_state = S_ULRD;
                    end else begin
                        n_pass = 2'd3;
                    end
                end else begin
                    if (r_pass == 2'd3) begin
                        n_we = 1'b1;
                        n_waddr = r_src[15:0];
                        n_wdata = r_cel;
                    end
                    if (r_cel[1] && src_end > {8'd0, r_free}) begin
                        n_res.status = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        if (r_cel[1]) n_dst = r_dst + cell_n[16:0];
                        n_src = (src_end > 25'h1FFFF) ? 17'h1FFFF : src_end[16:0];
                        n_state = S_URD;
                    end
                end
            end
            // slide pass
            S_CRD: begin
                if (r_src >= r_free) begin
                    n_free = r_dst;
                    if ({1'b0, r_dst} + {1'b0, r_cmd.margin} > {1'b0, lim}) n_res.status = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_raddr = r_src[15:0];
                    n_state = S_CEX;
                end
            end
            S_CEX: begin
                n_cel = r_rdata;
                if (!r_rdata[1]) begin
                    n_src = (src_end > 25'h1FFFF) ? 17'h1FFFF : src_end[16:0];
                    n_state = S_CRD;
                end else if (src_end > {8'd0, r_free}) begin
                    n_res.status = 1'b1;
                    n_state = S_DONE;
                end else begin
                    // clear the mark in place, then copy the whole chunk down
                    n_we = 1'b1;
                    n_waddr = r_src[15:0];
                    n_wdata = r_rdata & ~32'd2;
                    n_cnt = 17'd0;
                    n_pass = 2'd2;
                    n_state = S_CMRD;
                end
            end
            S_CMRD: begin
                if ({8'd0, r_cnt} >= cell_n) begin
                    n_dst = r_dst + cell_n[16:0];
                    n_src = src_end[16:0];
                    n_state = S_CRD;
                end else begin
                    n_raddr = r_src[15:0] + r_cnt[15:0];
                    n_state = S_CMWR;
                    n_pass = 2'd2;
                end
            end
            S_CMWR: begin
                if (r_pass == 2'd0) begin
                    // finish marking retreat step
                    n_we = 1'b1;
                    n_waddr = r_cur[15:0];
                    n_wdata = put_offset({28'd0, CellLink}, r_prv);
                    n_cur = r_prv[16:0] - 17'd1;
                    n_prv = r_fresh[31:3];
                    n_state = S_MRD;
                end else begin
                    n_we = 1'b1;
                    n_waddr = r_dst[15:0] + r_cnt[15:0];
                    n_wdata = r_rdata;
                    n_cnt = r_cnt + 17'd1;
                    n_state = S_CMRD;
                end
            end
            S_DONE: begin
                n_res.free_level = n_free;
                n_ovalid = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### src/mccs_checker.sv
// Port-level checker for the chunk store, bound to the top level.
// Depends on the top-level module through the bind below.
`default_nettype none
module mccs_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic i_ready,
    input wire logic o_valid,
    input wire logic o_ready,
    input wire logic [16:0] o_free
);
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid) else $error("result dropped");
    a_one_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready |=> !i_ready) else $error("second transfer accepted");
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !i_ready) else $error("input open while result pending");
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_free <= 17'd65536) else $error("free level out of range");
endmodule

bind mark_compact_chunk_store mccs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_valid(i_cmd.valid), .i_ready(i_cmd.ready),
    .o_valid(o_res.valid), .o_ready(o_res.ready),
    .o_free(o_res.data.free_level)
);
`default_nettype wire
